// ===== sv/lift_overrun_stop_predictor_top_assert.svh =====
// Assertion macros for the lift overrun stop predictor.
`ifndef LIFT_OVERRUN_STOP_PREDICTOR_TOP_ASSERT_SVH
`define LIFT_OVERRUN_STOP_PREDICTOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define LOPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// Next-cycle implication, disabled during reset.
`define LOPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define LOPS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LOPS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/lops_pkg.sv =====
// Shared widths, codes and controller/datapath interface types of the stop predictor.
package lops_pkg;

  localparam int MODE_W     = 2;
  localparam int TIME_W     = 32;
  localparam int HGT_W      = 24;
  localparam int SKID_W     = 16;
  localparam int STS_W      = 2;
  localparam int SUM_W      = 48;
  localparam int CNT_W      = 16;
  localparam int SPD_W      = 32;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_FIELD_W = 1 + SKID_W + STS_W;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Shared serial divider: unsigned magnitudes, one quotient bit per cycle.
  localparam int DIVIDEND_W = 48;
  localparam int DIVISOR_W  = 33;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  localparam logic [CNT_W-1:0]  MAX_SAMPLES = 16'd65535;
  localparam logic [SKID_W-1:0] SKID_RESET  = 16'd100;

  typedef enum logic [MODE_W-1:0] {
    MODE_START  = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_STOP   = 2'd2,
    MODE_ARRIVE = 2'd3
  } mode_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 2'd0,
    STS_IGNORED  = 2'd1,
    STS_NO_SPEED = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_HGT  = 2'd0,
    CFG_TARGET_HGT = 2'd1,
    CFG_SKID_TIME  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_VEL  = 2'd0,
    DIV_MEAN = 2'd1,
    DIV_SKID = 2'd2
  } div_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_VEL_WAIT,
    ST_MEAN_START,
    ST_MEAN_WAIT,
    ST_PROD,
    ST_CMP,
    ST_MARK_WAIT,
    ST_ARRIVE_WAIT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic    load_in;
    logic    do_start;
    logic    div_start;
    div_op_e div_op;
    logic    acc_vel;
    logic    latch_mean;
    logic    mul_prod;
    logic    set_stop;
    logic    mark_height;
    logic    set_speed;
    logic    zero_speed;
    logic    arrive_clear;
    logic    set_skid;
    logic    set_status;
    status_e status;
    logic    push;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  enabled;
    logic  dt_zero;
    logic  count_zero;
    logic  speed_zero;
    logic  div_done;
    logic  div_busy;
    logic  out_busy;
  } stat_t;

endpackage

// ===== sv/lops_div.sv =====
// Restoring serial divider for unsigned magnitudes, one quotient bit per cycle.
module lops_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [lops_pkg::DIVIDEND_W-1:0] dividend_i,
  input  logic [lops_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [lops_pkg::DIVIDEND_W-1:0] quot_o
);
  import lops_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  dsr_q;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_next;

  // The quotient register doubles as the dividend shift register.
  assign trial    = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits     = trial >= {1'b0, dsr_q};
  assign diff     = trial - {1'b0, dsr_q};
  assign rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== sv/lops_dp.sv =====
// Datapath: configuration, predictor state, operand selection, divider and result register.
module lops_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lops_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lops_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [lops_pkg::IN_DATA_W-1:0]  in_tdata_i,
  input  logic [lops_pkg::MODE_W-1:0]     in_tuser_i,
  input  lops_pkg::cmd_t                  cmd_i,
  output lops_pkg::stat_t                 stat_o,
  input  logic                           out_tready_i,
  output logic                           out_tvalid_o,
  output logic [lops_pkg::OUT_DATA_W-1:0] out_tdata_o
);
  import lops_pkg::*;

  localparam int VEL_NUM_W = 45;
  localparam int DM_W      = HGT_W + 1;
  localparam int DM1K_W    = 35;
  localparam int PROD_W    = SPD_W + SKID_W + 1;
  localparam int CMP_W     = PROD_W + 1;
  localparam int PAD_W     = OUT_DATA_W - OUT_FIELD_W;

  localparam logic signed [VEL_NUM_W-1:0] VEL_SCALE = VEL_NUM_W'(1000000);
  localparam logic        [DM1K_W-1:0]    MS_SCALE  = DM1K_W'(1000);
  localparam logic signed [CMP_W-1:0]     CMP_SCALE = CMP_W'(1000);
  localparam logic [DIVIDEND_W-1:0] S32_MAX_MAG = DIVIDEND_W'(64'h7FFF_FFFF);
  localparam logic [DIVIDEND_W-1:0] S32_MIN_MAG = DIVIDEND_W'(64'h8000_0000);
  localparam logic [DIVIDEND_W-1:0] SKID_MAX_MAG = DIVIDEND_W'(16'hFFFF);
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Signed 32-bit saturation of a quotient given as sign and magnitude.
  function automatic logic [SPD_W-1:0] clamp_s32(input logic neg,
                                                 input logic [DIVIDEND_W-1:0] mag);
    logic [SPD_W-1:0] res;
    if (!neg) begin
      res = (mag > S32_MAX_MAG) ? {1'b0, {(SPD_W-1){1'b1}}} : mag[SPD_W-1:0];
    end else begin
      res = (mag > S32_MIN_MAG) ? {1'b1, {(SPD_W-1){1'b0}}} : SPD_W'(-mag[SPD_W-1:0]);
    end
    return res;
  endfunction

  // Configuration registers.
  logic signed [HGT_W-1:0] start_q, tgt_q;
  logic [SKID_W-1:0]       skid_q;

  // Predictor state.
  logic                    enabled_q;
  logic [TIME_W-1:0]       last_time_q;
  logic signed [HGT_W-1:0] last_hgt_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0]        count_q;
  logic signed [HGT_W-1:0] stop_hgt_q;
  logic signed [SPD_W-1:0] stop_spd_q;

  // Latched request and working registers.
  mode_e                    mode_q;
  logic [TIME_W-1:0]        time_q;
  logic signed [HGT_W-1:0]  hgt_q;
  logic                     div_neg_q;
  logic signed [SPD_W-1:0]  mean_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     res_stop_q;
  logic [SKID_W-1:0]        res_skid_q;
  status_e                  res_status_q;
  logic                     out_tvalid_q;
  logic [OUT_DATA_W-1:0]    out_tdata_q;

  // Elapsed time as a signed 33-bit difference.
  logic signed [TIME_W:0]   dt;
  logic                     dt_neg;
  logic [DIVISOR_W-1:0]     dt_mag;
  logic signed [DM_W-1:0]   dh;
  logic signed [VEL_NUM_W-1:0] vel_num;
  logic [VEL_NUM_W-1:0]     vel_mag;
  logic [SUM_W-1:0]         sum_mag;
  logic signed [DM_W-1:0]   dstop;
  logic [DM_W-1:0]          dm;
  logic [DM1K_W-1:0]        dm1k;
  logic [SPD_W-1:0]         spd_mag;

  logic [DIVIDEND_W-1:0]    div_dividend;
  logic [DIVISOR_W-1:0]     div_divisor;
  logic                     div_neg;
  logic                     div_busy, div_done;
  logic [DIVIDEND_W-1:0]    quot;
  logic signed [SPD_W-1:0]  q_clamped;

  logic signed [SUM_W:0]    sum_ext;
  logic signed [SUM_W-1:0]  sum_sat;

  logic signed [HGT_W+1:0]  s_ext, t_ext, h_ext, mid2, h2;
  logic signed [CMP_W-1:0]  t1k, h1k, h0k;
  logic                     ascending, stop_hit;

  assign dt      = $signed({1'b0, time_q}) - $signed({1'b0, last_time_q});
  assign dt_neg  = dt[TIME_W];
  assign dt_mag  = dt_neg ? DIVISOR_W'(-dt) : DIVISOR_W'(dt);
  assign dh      = $signed({hgt_q[HGT_W-1], hgt_q}) - $signed({last_hgt_q[HGT_W-1], last_hgt_q});
  assign vel_num = VEL_NUM_W'(dh) * VEL_SCALE;
  assign vel_mag = vel_num[VEL_NUM_W-1] ? VEL_NUM_W'(-vel_num) : VEL_NUM_W'(vel_num);
  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign dstop   = $signed({hgt_q[HGT_W-1], hgt_q})
                 - $signed({stop_hgt_q[HGT_W-1], stop_hgt_q});
  assign dm      = dstop[DM_W-1] ? DM_W'(-dstop) : DM_W'(dstop);
  assign dm1k    = DM1K_W'(dm) * MS_SCALE;
  assign spd_mag = stop_spd_q[SPD_W-1] ? SPD_W'(-stop_spd_q) : SPD_W'(stop_spd_q);

  always_comb begin
    unique case (cmd_i.div_op)
      DIV_VEL: begin
        div_dividend = DIVIDEND_W'(vel_mag);
        div_divisor  = dt_mag;
        div_neg      = vel_num[VEL_NUM_W-1] ^ dt_neg;
      end
      DIV_MEAN: begin
        div_dividend = sum_mag;
        div_divisor  = DIVISOR_W'(count_q);
        div_neg      = sum_q[SUM_W-1];
      end
      DIV_SKID: begin
        div_dividend = DIVIDEND_W'(dm1k);
        div_divisor  = DIVISOR_W'(spd_mag);
        div_neg      = 1'b0;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
        div_neg      = 1'b0;
      end
    endcase
  end

  lops_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign q_clamped = $signed(clamp_s32(div_neg_q, quot));

  // Saturating accumulate of one sample velocity.
  assign sum_ext = $signed({sum_q[SUM_W-1], sum_q}) + (SUM_W+1)'(q_clamped);
  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  // Stop test: half-way gate, then the exact comparison in micrometre-milliseconds.
  assign s_ext     = (HGT_W+2)'(start_q);
  assign t_ext     = (HGT_W+2)'(tgt_q);
  assign h_ext     = (HGT_W+2)'(last_hgt_q);
  assign mid2      = s_ext + t_ext;
  assign h2        = h_ext + h_ext;
  assign t1k       = CMP_W'(tgt_q) * CMP_SCALE;
  assign h1k       = CMP_W'(last_hgt_q) * CMP_SCALE;
  assign h0k       = t1k - CMP_W'(prod_q);
  assign ascending = start_q < tgt_q;
  always_comb begin
    if (ascending) begin
      stop_hit = !(h2 < mid2) && (h1k > h0k);
    end else begin
      stop_hit = !(h2 > mid2) && (h1k < h0k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      tgt_q   <= '0;
      skid_q  <= SKID_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_HGT:  start_q <= $signed(cfg_data_i[HGT_W-1:0]);
        CFG_TARGET_HGT: tgt_q   <= $signed(cfg_data_i[HGT_W-1:0]);
        CFG_SKID_TIME:  skid_q  <= cfg_data_i[SKID_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      last_time_q <= '0;
      last_hgt_q  <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      stop_hgt_q  <= '0;
      stop_spd_q  <= '0;
    end else begin
      priority if (cmd_i.do_start) begin
        enabled_q   <= 1'b1;
        last_time_q <= '0;
        last_hgt_q  <= start_q;
        sum_q       <= '0;
        count_q     <= '0;
      end else if (cmd_i.arrive_clear) begin
        enabled_q <= 1'b0;
        sum_q     <= '0;
        count_q   <= '0;
      end else if (cmd_i.acc_vel) begin
        if (count_q != MAX_SAMPLES) begin
          sum_q   <= sum_sat;
          count_q <= count_q + 1'b1;
        end
        last_time_q <= time_q;
        last_hgt_q  <= hgt_q;
      end else begin
        enabled_q <= enabled_q;
      end
      if (cmd_i.mark_height) begin
        stop_hgt_q <= hgt_q;
      end
      if (cmd_i.zero_speed) begin
        stop_spd_q <= '0;
      end else if (cmd_i.set_speed) begin
        stop_spd_q <= q_clamped;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q       <= mode_e'(in_tuser_i);
      time_q       <= in_tdata_i[TIME_W-1:0];
      hgt_q        <= $signed(in_tdata_i[TIME_W +: HGT_W]);
      res_stop_q   <= 1'b0;
      res_skid_q   <= '0;
      res_status_q <= STS_OK;
    end else begin
      if (cmd_i.set_stop) begin
        res_stop_q <= stop_hit;
      end
      if (cmd_i.set_skid) begin
        res_skid_q <= (quot > SKID_MAX_MAG) ? {SKID_W{1'b1}} : quot[SKID_W-1:0];
      end
      if (cmd_i.set_status) begin
        res_status_q <= cmd_i.status;
      end
    end
    if (cmd_i.div_start) begin
      div_neg_q <= div_neg;
    end
    if (cmd_i.latch_mean) begin
      mean_q <= q_clamped;
    end
    if (cmd_i.mul_prod) begin
      prod_q <= PROD_W'(mean_q) * PROD_W'($signed({1'b0, skid_q}));
    end
    if (cmd_i.push) begin
      out_tdata_q <= {{PAD_W{1'b0}}, res_status_q, res_skid_q, res_stop_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_tvalid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_tvalid_q <= 1'b1;
    end else if (out_tready_i) begin
      out_tvalid_q <= 1'b0;
    end
  end

  assign out_tvalid_o = out_tvalid_q;
  assign out_tdata_o  = out_tdata_q;

  assign stat_o.mode       = mode_q;
  assign stat_o.enabled    = enabled_q;
  assign stat_o.dt_zero    = (time_q == last_time_q);
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.speed_zero = (stop_spd_q == '0);
  assign stat_o.div_done   = div_done;
  assign stat_o.div_busy   = div_busy;
  assign stat_o.out_busy   = out_tvalid_q && !out_tready_i;

endmodule

// ===== sv/lops_ctrl.sv =====
// Controller state machine that sequences one request through the datapath.
module lops_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_tvalid_i,
  output logic            in_tready_o,
  input  lops_pkg::stat_t stat_i,
  output lops_pkg::cmd_t  cmd_o
);
  import lops_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_tready_o   = 1'b1;
        cmd_o.load_in = in_tvalid_i;
        if (in_tvalid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_FINISH;
        priority if (stat_i.mode == MODE_START) begin
          cmd_o.do_start = 1'b1;
        end else if (!stat_i.enabled) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STS_IGNORED;
        end else begin
          unique case (stat_i.mode)
            MODE_SAMPLE: begin
              if (stat_i.dt_zero) begin
                cmd_o.set_status = 1'b1;
                cmd_o.status     = STS_IGNORED;
              end else begin
                cmd_o.div_start = 1'b1;
                cmd_o.div_op    = DIV_VEL;
                state_d         = ST_VEL_WAIT;
              end
            end
            MODE_STOP: begin
              cmd_o.mark_height = 1'b1;
              if (stat_i.count_zero) begin
                cmd_o.zero_speed = 1'b1;
                cmd_o.set_status = 1'b1;
                cmd_o.status     = STS_NO_SPEED;
              end else begin
                cmd_o.div_start = 1'b1;
                cmd_o.div_op    = DIV_MEAN;
                state_d         = ST_MARK_WAIT;
              end
            end
            MODE_ARRIVE: begin
              cmd_o.arrive_clear = 1'b1;
              if (stat_i.speed_zero) begin
                cmd_o.set_status = 1'b1;
                cmd_o.status     = STS_NO_SPEED;
              end else begin
                cmd_o.div_start = 1'b1;
                cmd_o.div_op    = DIV_SKID;
                state_d         = ST_ARRIVE_WAIT;
              end
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_VEL_WAIT: begin
        cmd_o.div_op = DIV_VEL;
        if (stat_i.div_done) begin
          cmd_o.acc_vel = 1'b1;
          state_d       = ST_MEAN_START;
        end
      end
      ST_MEAN_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_MEAN;
        state_d         = ST_MEAN_WAIT;
      end
      ST_MEAN_WAIT: begin
        cmd_o.div_op = DIV_MEAN;
        if (stat_i.div_done) begin
          cmd_o.latch_mean = 1'b1;
          state_d          = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.mul_prod = 1'b1;
        state_d        = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.set_stop = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_MARK_WAIT: begin
        cmd_o.div_op = DIV_MEAN;
        if (stat_i.div_done) begin
          cmd_o.set_speed = 1'b1;
          state_d         = ST_FINISH;
        end
      end
      ST_ARRIVE_WAIT: begin
        cmd_o.div_op = DIV_SKID;
        if (stat_i.div_done) begin
          cmd_o.set_skid = 1'b1;
          state_d        = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/lift_overrun_stop_predictor_top.sv =====
// A height sample runs two 48-step serial divisions (sample and mean velocity); a stop
// mark or an arrive runs at most one, and a start or an ignored request runs none.
// Throughput: one request at a time; the next request is taken once the previous is done,
// while its result may still wait in the output register.
// Reset (rst_ni, async, active low) clears control and move state and sets skid time to 100 ms.
// Top level of the lift overrun stop predictor.
`include "lift_overrun_stop_predictor_top_assert.svh"
module lift_overrun_stop_predictor_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port: 0 start height, 1 target height, 2 skid time.
  input  logic                            cfg_we_i,
  input  logic [lops_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lops_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Request stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lops_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // time_us[31:0], height_um[55:32]
  input  logic [lops_pkg::MODE_W-1:0]     s_axis_tuser,  // mode[1:0]
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lops_pkg::OUT_DATA_W-1:0] m_axis_tdata   // stop_now[0], measured_skid_ms[16:1],
                                                         // status[18:17], zero pad above
);
  import lops_pkg::*;

  // The controller only issues commands; every value lives in the datapath,
  // which reports back a small set of status flags.
  cmd_t  cmd;
  stat_t stat;

  lops_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds configuration, the velocity history, the shared serial
  // divider (used for sample velocity, mean velocity and measured skid) and the
  // output register that decouples a waiting result from the next request.
  lops_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_tdata_i   (s_axis_tdata),
    .in_tuser_i   (s_axis_tuser),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata)
  );

  // A result is only moved into the output register when that register is free.
  `LOPS_ASSERT_IMP(a_push_free, clk_i, rst_ni, cmd.push, !m_axis_tvalid || m_axis_tready)
  // The shared divider is never restarted while it is still working.
  `LOPS_ASSERT_IMP(a_div_idle, clk_i, rst_ni, cmd.div_start, !stat.div_busy)
  // Once a request is taken, the port closes until that request completes.
  `LOPS_ASSERT_NXT(a_one_req, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // A new result only appears as the outcome of a push.
  `LOPS_ASSERT_IMP(a_rise_push, clk_i, rst_ni, $rose(m_axis_tvalid), $past(cmd.push))

endmodule

// ===== bench/lops_stop_checker.sv =====
// Result checker for the lift overrun stop predictor: predicts each result and compares it.
`timescale 1ns / 100ps
module lops_stop_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lops_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lops_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [lops_pkg::IN_DATA_W-1:0]  s_tdata_i,   // time_us[31:0], height_um[55:32]
  input  logic [lops_pkg::MODE_W-1:0]     s_tuser_i,   // mode[1:0]
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [lops_pkg::OUT_DATA_W-1:0] m_tdata_i,   // stop_now[0], measured_skid_ms[16:1],
                                                       // status[18:17]
  output int                              error_count_o,
  output int                              pending_o
);
  import lops_pkg::*;

  typedef struct packed {
    logic              stop_now;
    logic [SKID_W-1:0] skid_ms;
    status_e           status;
  } stop_result_t;

  localparam longint I32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint I32_MIN = -I32_MAX - 1;
  localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  // Configuration copy.
  logic signed [HGT_W-1:0] start_hgt;
  logic signed [HGT_W-1:0] target_hgt;
  logic [SKID_W-1:0]       skid_time;

  // Move state as the block should hold it.
  logic                    moving;
  logic [TIME_W-1:0]       last_time;
  logic signed [HGT_W-1:0] last_hgt;
  longint                  vel_sum;
  int                      vel_count;
  logic signed [HGT_W-1:0] stop_hgt;
  int                      stop_speed;

  stop_result_t awaited_q[$];
  stop_result_t want;
  int           errors;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint mean_speed();
    longint cnt;
    if (vel_count == 0) return 0;
    cnt = vel_count;
    return clamp(vel_sum / cnt, I32_MIN, I32_MAX);
  endfunction

  // Stop once past the half-way point and beyond target minus mean speed times skid time.
  function automatic logic stop_flag();
    longint s, t, h, skid, aim;
    s = start_hgt;
    t = target_hgt;
    h = last_hgt;
    skid = skid_time;
    aim = t * 1000 - mean_speed() * skid;
    if (s < t) return (2 * h >= s + t) && (h * 1000 > aim);
    return (2 * h <= s + t) && (h * 1000 < aim);
  endfunction

  function automatic stop_result_t predict_request(mode_e mode, logic [TIME_W-1:0] tnow,
                                                   logic signed [HGT_W-1:0] h);
    stop_result_t r;
    longint now, prev, dt, dh, v, travel, spd, ms;
    r.stop_now = 1'b0;
    r.skid_ms = '0;
    r.status = STS_OK;
    if (mode == MODE_START) begin
      moving = 1'b1;
      last_time = '0;
      last_hgt = start_hgt;
      vel_sum = 0;
      vel_count = 0;
    end else if (!moving) begin
      r.status = STS_IGNORED;
    end else if (mode == MODE_SAMPLE) begin
      now = tnow;
      prev = last_time;
      dt = now - prev;
      if (dt == 0) begin
        r.status = STS_IGNORED;
      end else begin
        dh = h;
        prev = last_hgt;
        dh = dh - prev;
        v = clamp((dh * 1000000) / dt, I32_MIN, I32_MAX);
        if (vel_count < int'(MAX_SAMPLES)) begin
          vel_sum = clamp(vel_sum + v, SUM_MIN, SUM_MAX);
          vel_count++;
        end
        last_time = tnow;
        last_hgt = h;
        r.stop_now = stop_flag();
      end
    end else if (mode == MODE_STOP) begin
      stop_hgt = h;
      if (vel_count == 0) begin
        stop_speed = 0;
        r.status = STS_NO_SPEED;
      end else begin
        stop_speed = int'(mean_speed());
      end
    end else begin
      travel = h;
      prev = stop_hgt;
      travel = travel - prev;
      if (travel < 0) travel = -travel;
      spd = stop_speed;
      if (spd < 0) spd = -spd;
      if (spd == 0) begin
        r.status = STS_NO_SPEED;
      end else begin
        ms = (travel * 1000) / spd;
        r.skid_ms = (ms > 65535) ? 16'hFFFF : ms[SKID_W-1:0];
      end
      vel_sum = 0;
      vel_count = 0;
      moving = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_hgt = '0;
      target_hgt = '0;
      skid_time = SKID_RESET;
      moving = 1'b0;
      last_time = '0;
      last_hgt = '0;
      vel_sum = 0;
      vel_count = 0;
      stop_hgt = '0;
      stop_speed = 0;
      awaited_q.delete();
      errors = 0;
      error_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_START_HGT:  start_hgt = cfg_data_i[HGT_W-1:0];
          CFG_TARGET_HGT: target_hgt = cfg_data_i[HGT_W-1:0];
          CFG_SKID_TIME:  skid_time = cfg_data_i[SKID_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        awaited_q.insert(awaited_q.size(),
                         predict_request(mode_e'(s_tuser_i), s_tdata_i[TIME_W-1:0],
                                         s_tdata_i[TIME_W +: HGT_W]));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result, tdata %h", $time, m_tdata_i);
          errors++;
        end else begin
          want = awaited_q.pop_front();
          if (m_tdata_i[0] !== want.stop_now) begin
            $display("%0t: stop_now expected %0d, got %0d", $time, want.stop_now, m_tdata_i[0]);
            errors++;
          end
          if (m_tdata_i[16:1] !== want.skid_ms) begin
            $display("%0t: measured_skid_ms expected %0d, got %0d", $time, want.skid_ms,
                     m_tdata_i[16:1]);
            errors++;
          end
          if (m_tdata_i[18:17] !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     m_tdata_i[18:17]);
            errors++;
          end
        end
      end
      error_count_o <= errors;
      pending_o <= awaited_q.size();
    end
  end

endmodule

// ===== bench/lift_overrun_stop_predictor_top_test.sv =====
// Stimulus and verdict for the lift overrun stop predictor, with the checker beside the block.
`timescale 1ns / 100ps
module lift_overrun_stop_predictor_top_test;
  import lops_pkg::*;

  // A run counts as hung when nothing moves on either stream until the idle count reaches
  // this limit. The work of the slowest correct request plus the longest input gap and the
  // longest result stall stays far below it, so this leaves a wide margin.
  localparam int HANG_LIMIT = 4000;
  localparam int REQUEST_GOAL = 1350;
  localparam int HGT_MAX = 8388607;
  localparam int HGT_MIN = -8388608;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;    // time_us[31:0], height_um[55:32]
  logic [MODE_W-1:0]     s_tuser = '0;    // mode[1:0]
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // stop_now[0], measured_skid_ms[16:1], status[18:17]

  int   errors;
  int   pending;
  int   sent = 0;
  int   idle_cycles = 0;
  // When set, neither side inserts gaps, so the block runs back to back.
  logic quiet = 1'b0;

  // The settings the stimulus currently assumes, used to shape realistic moves.
  int   cur_start = 0;
  int   cur_target = 0;

  lift_overrun_stop_predictor_top DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_tdata)
  );

  lops_stop_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_tvalid_i    (s_valid),
    .s_tready_i    (s_ready),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .m_tvalid_i    (m_valid),
    .m_tready_i    (m_ready),
    .m_tdata_i     (m_tdata),
    .error_count_o (errors),
    .pending_o     (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Gap length for either side: mostly none, sometimes a few cycles, now and then a long
  // one that spans several phases of the block's internal sequence.
  function automatic int random_pause();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic int clip_hgt(longint v);
    if (v > HGT_MAX) return HGT_MAX;
    if (v < HGT_MIN) return HGT_MIN;
    return int'(v);
  endfunction

  // Result side: ready runs of random length broken by stalls, or always ready when quiet.
  initial begin : result_backpressure
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        m_ready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if (m_ready) begin
        m_ready <= 1'b0;
        hold = random_pause();
      end else begin
        m_ready <= 1'b1;
        hold = $urandom_range(0, 30);
      end
    end
  end

  // Watchdog: any accepted request or result restarts the count.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= HANG_LIMIT) begin
        $display("lift_overrun_stop_predictor_top_test failed");
        $finish;
      end
    end
  end

  // Presents one request and returns at the clock edge that accepts it. The caller must
  // call again, or drain, before the next falling edge passes, so that valid never stays
  // high on an already accepted request. With no gap the new request replaces the old one
  // in a single assignment.
  task automatic send_request(mode_e mode, logic [TIME_W-1:0] stamp, logic [HGT_W-1:0] hgt);
    int gap;
    gap = random_pause();
    @(negedge clk);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {hgt, stamp};
    do @(posedge clk); while (!s_ready);
    sent++;
  endtask

  // Drops valid and waits until every predicted result has come back, which leaves the
  // block idle and safe for register writes.
  task automatic drain_requests();
    @(negedge clk);
    s_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_settings(int start, int target, int skid);
    cfg_write(CFG_START_HGT, start[HGT_W-1:0]);
    cfg_write(CFG_TARGET_HGT, target[HGT_W-1:0]);
    cfg_write(CFG_SKID_TIME, {8'd0, skid[SKID_W-1:0]});
    cur_start = start;
    cur_target = target;
  endtask

  // One move: start, samples walking from the start height toward the target with jitter,
  // a stop mark somewhere past the middle, and an arrive with some overshoot. A few requests
  // break the pattern: repeated or reversed timestamps, huge time jumps and random requests.
  task automatic run_move();
    int n, step, spread, stop_at, hgt, i, r;
    logic [TIME_W-1:0] stamp;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(2, 16);
    step = (cur_target - cur_start) / n;
    spread = ((step < 0) ? -step : step) / 4 + 100;
    stop_at = $urandom_range(n / 2, n - 1);
    send_request(MODE_START, $urandom, HGT_W'($urandom));
    stamp = '0;
    hgt = cur_start;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_request(mode_e'($urandom_range(0, 3)), $urandom, HGT_W'($urandom));
      end else begin
        hgt = clip_hgt(longint'(hgt) + step + int'($urandom_range(0, spread)) - spread / 2);
        if (r == 1) begin
          stamp = stamp - $urandom_range(1, 5000);       // clock went backwards
        end else if (r == 2) begin
          stamp = stamp + $urandom;                      // large jump, may wrap
        end else if (r != 3) begin                       // r == 3 repeats the timestamp
          stamp = stamp + $urandom_range(2000, 50000);
        end
        send_request(MODE_SAMPLE, stamp, hgt[HGT_W-1:0]);
      end
      if (i == stop_at) send_request(MODE_STOP, $urandom, hgt[HGT_W-1:0]);
    end
    hgt = clip_hgt(longint'(hgt) + (step * int'($urandom_range(0, 3))) / 2
                   + int'($urandom_range(0, spread)) - spread / 2);
    send_request(MODE_ARRIVE, $urandom, hgt[HGT_W-1:0]);
  endtask

  // New settings for a random phase: mostly moderate heights and skid times, sometimes the
  // full register range, sometimes the extremes.
  task automatic random_settings();
    int r, s, t, k;
    r = $urandom_range(0, 7);
    if (r == 0) begin
      s = $urandom_range(0, 16777215) + HGT_MIN;
      t = $urandom_range(0, 16777215) + HGT_MIN;
      k = $urandom_range(0, 65535);
    end else if (r == 1) begin
      s = $urandom_range(0, 1) ? HGT_MAX : HGT_MIN;
      t = $urandom_range(0, 1) ? HGT_MAX : HGT_MIN;
      k = $urandom_range(0, 1) ? 65535 : 0;
    end else begin
      s = int'($urandom_range(0, 200000)) - 100000;
      t = ($urandom_range(0, 9) == 0) ? s : int'($urandom_range(0, 200000)) - 100000;
      k = $urandom_range(0, 500);
    end
    load_settings(s, t, k);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Requests while the block is disabled are all ignored.
    send_request(MODE_SAMPLE, 32'h1234_5678, 24'h00_1000);
    send_request(MODE_STOP, 32'h0, 24'h7F_FFFF);
    send_request(MODE_ARRIVE, 32'hFFFF_FFFF, 24'h80_0000);
    drain_requests();

    // Rising move over the full height range with the longest skid time.
    load_settings(HGT_MIN, HGT_MAX, 65535);
    send_request(MODE_START, 32'h0, 24'h0);
    send_request(MODE_SAMPLE, 32'h0, 24'h00_0100);        // no time elapsed
    send_request(MODE_SAMPLE, 32'd1000, 24'h7F_FFFF);     // speed saturates high
    send_request(MODE_SAMPLE, 32'hFFFF_FFFF, 24'h80_0000);
    send_request(MODE_SAMPLE, 32'd500, 24'h00_0000);      // time runs backwards
    send_request(MODE_STOP, 32'h0, 24'h7F_FFFF);
    send_request(MODE_ARRIVE, 32'h0, 24'h80_0000);
    // Stop mark and arrive with no speed data.
    send_request(MODE_START, 32'h0, 24'h0);
    send_request(MODE_STOP, 32'h0, 24'h00_0010);
    send_request(MODE_ARRIVE, 32'h0, 24'h00_0020);
    drain_requests();

    // Falling move over the full range with no skid time; restart while enabled.
    load_settings(HGT_MAX, HGT_MIN, 0);
    send_request(MODE_START, 32'h0, 24'h0);
    send_request(MODE_SAMPLE, 32'd1, 24'h7F_FFFF);
    send_request(MODE_SAMPLE, 32'd2, 24'h00_0000);
    send_request(MODE_SAMPLE, 32'd3, 24'h80_0000);
    send_request(MODE_STOP, 32'h0, 24'h80_0000);
    send_request(MODE_START, 32'h0, 24'h0);
    send_request(MODE_START, 32'h0, 24'h0);
    send_request(MODE_SAMPLE, 32'hFFFF_FFFF, 24'h80_0000);
    send_request(MODE_ARRIVE, 32'h0, 24'h7F_FFFF);        // stop speed still latched

    // Random part: phases of new settings followed by a few moves each.
    while (sent < REQUEST_GOAL) begin
      drain_requests();
      random_settings();
      quiet = ($urandom_range(0, 5) == 0);
      repeat ($urandom_range(1, 4)) run_move();
    end

    drain_requests();
    quiet = 1'b0;
    // Let any stray result surface before the verdict.
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("lift_overrun_stop_predictor_top_test passed");
    end else begin
      $display("lift_overrun_stop_predictor_top_test failed");
    end
    $finish;
  end

endmodule

// ===== lift_overrun_stop_predictor_top.f =====
+incdir+sv
sv/lops_pkg.sv
sv/lops_div.sv
sv/lops_dp.sv
sv/lops_ctrl.sv
sv/lift_overrun_stop_predictor_top.sv
bench/lops_stop_checker.sv
bench/lift_overrun_stop_predictor_top_test.sv
